// File: design/coalescing_range_set_core_assert.svh
// Assertion macros for the coalescing range set RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef COALESCING_RANGE_SET_CORE_ASSERT_SVH
`define COALESCING_RANGE_SET_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define CRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define CRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/crs_pkg.sv
// Shared types and constants for the coalescing range set.
// No dependencies.
package crs_pkg;

	localparam int unsigned MAX_SEGS_DEF  = 64;
	localparam int unsigned POS_WIDTH_DEF = 48;

	localparam int unsigned FIELD_W  = 48;
	localparam int unsigned LEN_W    = 49;
	localparam int unsigned SUM_W    = 49;
	localparam int unsigned ENTRY_W  = FIELD_W + LEN_W;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned HIDX_W   = 6;
	localparam int unsigned RCNT_W   = 7;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_RANGE = 2'd3
	} crs_status_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC,
		PTR_J,
		PTR_LAST
	} crs_ptr_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_COMPACT,
		WR_EXPAND,
		WR_MERGED
	} crs_wr_sel_t;

	typedef struct packed {
		logic        load;
		crs_ptr_op_t ptr_op;
		logic        set_i;
		logic        set_j;
		logic        merge;
		crs_wr_sel_t wr_sel;
		logic        commit;
		logic        set_status;
		crs_status_t status;
		logic        set_hit;
		logic        emit;
	} crs_cmd_t;

	typedef struct packed {
		logic lookup;
		logic empty_len;
		logic out_of_range;
		logic in_list;
		logic skip_ok;
		logic merge_ok;
		logic pos_before;
		logic pos_in;
		logic drop_zero;
		logic full;
		logic i_in_list;
		logic compact_need;
		logic compact_more;
		logic expand_more;
		logic out_free;
	} crs_stat_t;

endpackage

// File: design/crs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crs_ram #(
	parameter  int unsigned WIDTH = 1,
	parameter  int unsigned DEPTH = 2,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/crs_datapath.sv
// Datapath of the coalescing range set: request registers, segment RAM,
// scan pointer, merge window, count and sum, result register. Uses crs_pkg, crs_ram and the assert header.
`include "coalescing_range_set_core_assert.svh"
module crs_datapath #(
	parameter  int unsigned MAX_SEGS  = crs_pkg::MAX_SEGS_DEF,
	parameter  int unsigned POS_WIDTH = crs_pkg::POS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  crs_pkg::crs_cmd_t               cmd,
	output crs_pkg::crs_stat_t              stat,
	input  logic                            req_type,
	input  logic [crs_pkg::FIELD_W-1:0]     range_start,
	input  logic [crs_pkg::FIELD_W-1:0]     range_length,
	input  logic [crs_pkg::FIELD_W-1:0]     position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [crs_pkg::STATUS_W-1:0]    status,
	output logic                            hit,
	output logic [crs_pkg::HIDX_W-1:0]      hit_index,
	output logic [crs_pkg::RCNT_W-1:0]      range_count,
	output logic [crs_pkg::SUM_W-1:0]       covered_total
);
	import crs_pkg::*;

	localparam int unsigned IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
	localparam int unsigned CW = $clog2(MAX_SEGS + 1);
	localparam logic [63:0] LIM_END = 64'd1 << POS_WIDTH;

	// request and working registers
	logic                lookup_q;
	logic [FIELD_W-1:0]  start_q;
	logic [FIELD_W-1:0]  len_q;
	logic [FIELD_W-1:0]  pos_q;
	logic [LEN_W-1:0]    end_q;
	logic [FIELD_W-1:0]  mstart_q;
	logic [LEN_W-1:0]    mend_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       count_q;
	logic [SUM_W-1:0]    sum_q;
	crs_status_t         status_q;
	logic                hit_q;
	logic [IW-1:0]       hidx_q;

	// result register
	logic                out_valid_q;
	crs_status_t         o_status_q;
	logic                o_hit_q;
	logic [IW-1:0]       o_hidx_q;
	logic [CW-1:0]       o_count_q;
	logic [SUM_W-1:0]    o_sum_q;

	logic [CW-1:0]       ptr_d;
	logic [CW-1:0]       drop;
	logic [ENTRY_W-1:0]  rdata;
	logic [FIELD_W-1:0]  rd_start;
	logic [LEN_W-1:0]    rd_len;
	logic [LEN_W-1:0]    rd_end;
	logic [LEN_W-1:0]    req_end;
	logic [LEN_W-1:0]    merged_len;
	logic                ram_we;
	logic [CW-1:0]       waddr_full;
	logic [ENTRY_W-1:0]  ram_wdata;

	assign rd_start   = rdata[ENTRY_W-1:LEN_W];
	assign rd_len     = rdata[LEN_W-1:0];
	assign rd_end     = {1'b0, rd_start} + rd_len;
	assign req_end    = {1'b0, range_start} + {1'b0, range_length};
	assign merged_len = mend_q - {1'b0, mstart_q};
	assign drop       = j_q - i_q;

	always_comb begin
		case (cmd.ptr_op)
			PTR_HOLD: ptr_d = ptr_q;
			PTR_ZERO: ptr_d = '0;
			PTR_INC:  ptr_d = ptr_q + CW'(1);
			PTR_DEC:  ptr_d = ptr_q - CW'(1);
			PTR_J:    ptr_d = j_q;
			PTR_LAST: ptr_d = count_q - CW'(1);
			default:  ptr_d = ptr_q;
		endcase
	end

	always_comb begin
		ram_we     = 1'b1;
		waddr_full = i_q;
		ram_wdata  = rdata;
		case (cmd.wr_sel)
			WR_COMPACT: waddr_full = ptr_q - (drop - CW'(1));
			WR_EXPAND:  waddr_full = ptr_q + CW'(1);
			WR_MERGED:  ram_wdata  = {mstart_q, merged_len};
			default:    ram_we     = 1'b0;
		endcase
	end

	crs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SEGS)
	) u_seg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_full[IW-1:0]),
		.wdata (ram_wdata),
		.raddr (ptr_d[IW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		stat.lookup       = lookup_q;
		stat.empty_len    = (len_q == '0);
		stat.out_of_range = (64'(end_q) > LIM_END);
		stat.in_list      = (ptr_q < count_q);
		stat.skip_ok      = (rd_end < {1'b0, start_q});
		stat.merge_ok     = ({1'b0, rd_start} <= end_q);
		stat.pos_before   = (pos_q < rd_start);
		stat.pos_in       = ({1'b0, pos_q} < rd_end);
		stat.drop_zero    = (j_q == i_q);
		stat.full         = (count_q >= CW'(MAX_SEGS));
		stat.i_in_list    = (i_q < count_q);
		stat.compact_need = (drop > CW'(1)) && (j_q < count_q);
		stat.compact_more = ((ptr_q + CW'(1)) < count_q);
		stat.expand_more  = (ptr_q > i_q);
		stat.out_free     = !out_valid_q || out_ready;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lookup_q <= req_type;
			start_q  <= range_start;
			len_q    <= range_length;
			pos_q    <= position;
			end_q    <= req_end;
			mstart_q <= range_start;
			mend_q   <= req_end;
			status_q <= STATUS_OK;
			hit_q    <= 1'b0;
			hidx_q   <= '0;
		end
		if (cmd.set_i) begin
			i_q <= ptr_q;
		end
		if (cmd.set_j) begin
			j_q <= ptr_q;
		end
		if (cmd.merge) begin
			if (rd_start < mstart_q) begin
				mstart_q <= rd_start;
			end
			if (rd_end > mend_q) begin
				mend_q <= rd_end;
			end
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.set_hit) begin
			hit_q  <= 1'b1;
			hidx_q <= ptr_q[IW-1:0];
		end
		if (cmd.emit) begin
			o_status_q <= status_q;
			o_hit_q    <= hit_q;
			o_hidx_q   <= hidx_q;
			o_count_q  <= count_q;
			o_sum_q    <= sum_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (cmd.merge) begin
				sum_q <= sum_q - rd_len;
			end else if (cmd.commit) begin
				sum_q <= sum_q + merged_len;
			end
			if (cmd.commit) begin
				if (j_q == i_q) begin
					count_q <= count_q + CW'(1);
				end else begin
					count_q <= count_q - drop + CW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign hit           = o_hit_q;
	assign hit_index     = HIDX_W'(o_hidx_q);
	assign range_count   = RCNT_W'(o_count_q);
	assign covered_total = o_sum_q;

	`CRS_ASSERT_ALWAYS(a_count_cap, count_q <= CW'(MAX_SEGS), "range count above capacity")
	`CRS_ASSERT_IMPLY(a_emit_free, cmd.emit, !out_valid_q || out_ready, "result beat overwritten")
	`CRS_ASSERT_IMPLY(a_shift_ptr, cmd.wr_sel == WR_COMPACT || cmd.wr_sel == WR_EXPAND,
		ptr_q < count_q, "tail shift outside the list")
	`CRS_ASSERT_IMPLY(a_new_slot, cmd.commit && (i_q == j_q), count_q < CW'(MAX_SEGS),
		"new slot taken with list full")

endmodule

// File: design/crs_ctrl.sv
// Controller of the coalescing range set: sequences check, scan, merge,
// tail shift, commit, lookup and result. Uses crs_pkg; drives crs_datapath.
module crs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  crs_pkg::crs_stat_t  stat,
	output crs_pkg::crs_cmd_t   cmd
);
	import crs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SKIP,
		S_MERGE,
		S_DECIDE,
		S_COMPACT,
		S_EXPAND,
		S_COMMIT,
		S_LOOK,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;
	logic   accept;

	assign accept   = in_valid && in_ready_q;
	assign in_ready = in_ready_q;

	always_comb begin
		cmd            = '0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.wr_sel     = WR_NONE;
		cmd.status     = STATUS_OK;
		state_d        = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.ptr_op = PTR_ZERO;
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.lookup) begin
					state_d = S_LOOK;
				end else if (stat.empty_len) begin
					cmd.set_status = 1'b1;
					cmd.status     = STATUS_EMPTY;
					state_d        = S_RESP;
				end else if (stat.out_of_range) begin
					cmd.set_status = 1'b1;
					cmd.status     = STATUS_RANGE;
					state_d        = S_RESP;
				end else begin
					state_d = S_SKIP;
				end
			end
			S_SKIP: begin
				if (stat.in_list && stat.skip_ok) begin
					cmd.ptr_op = PTR_INC;
				end else begin
					cmd.set_i = 1'b1;
					state_d   = S_MERGE;
				end
			end
			S_MERGE: begin
				if (stat.in_list && stat.merge_ok) begin
					cmd.merge  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end else begin
					cmd.set_j = 1'b1;
					state_d   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.drop_zero) begin
					if (stat.full) begin
						cmd.set_status = 1'b1;
						cmd.status     = STATUS_FULL;
						state_d        = S_RESP;
					end else if (stat.i_in_list) begin
						cmd.ptr_op = PTR_LAST;
						state_d    = S_EXPAND;
					end else begin
						state_d = S_COMMIT;
					end
				end else if (stat.compact_need) begin
					cmd.ptr_op = PTR_J;
					state_d    = S_COMPACT;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_COMPACT: begin
				cmd.wr_sel = WR_COMPACT;
				if (stat.compact_more) begin
					cmd.ptr_op = PTR_INC;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_EXPAND: begin
				cmd.wr_sel = WR_EXPAND;
				if (stat.expand_more) begin
					cmd.ptr_op = PTR_DEC;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.wr_sel = WR_MERGED;
				cmd.commit = 1'b1;
				state_d    = S_RESP;
			end
			S_LOOK: begin
				if (!stat.in_list || stat.pos_before) begin
					state_d = S_RESP;
				end else if (stat.pos_in) begin
					cmd.set_hit = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.ptr_op = PTR_INC;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == S_IDLE);
		end
	end

endmodule

// File: design/coalescing_range_set_core.sv
// Top level of the coalescing range set: controller plus datapath.
// Uses crs_pkg, crs_ctrl, crs_datapath (which holds crs_ram).
//
// Keeps up to MAX_SEGS sorted, disjoint, non-touching ranges in one RAM and
// handles one request at a time. A request walks the list one entry per
// cycle through the single read port of the segment RAM: a lookup walks
// until it finds or passes the position, and an insert scans the entries it
// meets, then shifts the tail entries if the list must open or close a gap.
// Zero-length and out-of-range inserts answer from the check without a
// walk. The list is empty after reset with no clearing pass. The result
// sits in an output register, so the next request may start while it waits.
module coalescing_range_set_core #(
	parameter int unsigned MAX_SEGS  = crs_pkg::MAX_SEGS_DEF,
	parameter int unsigned POS_WIDTH = crs_pkg::POS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [crs_pkg::FIELD_W-1:0]     range_start,
	input  logic [crs_pkg::FIELD_W-1:0]     range_length,
	input  logic [crs_pkg::FIELD_W-1:0]     position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [crs_pkg::STATUS_W-1:0]    status,
	output logic                            hit,
	output logic [crs_pkg::HIDX_W-1:0]      hit_index,
	output logic [crs_pkg::RCNT_W-1:0]      range_count,
	output logic [crs_pkg::SUM_W-1:0]       covered_total
);
	import crs_pkg::*;

	crs_cmd_t  cmd;
	crs_stat_t stat;

	crs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crs_datapath #(
		.MAX_SEGS  (MAX_SEGS),
		.POS_WIDTH (POS_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.range_start   (range_start),
		.range_length  (range_length),
		.position      (position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.hit           (hit),
		.hit_index     (hit_index),
		.range_count   (range_count),
		.covered_total (covered_total)
	);

endmodule

// File: bench/coalescing_range_set_core_tb.sv
// Testbench for coalescing_range_set_core: directed table, random region traffic, then closing table rows.
// Every result is checked against a behavioral copy of the range list or, for typed rows, the table's values.
// Depends on crs_pkg and the coalescing_range_set_core RTL.
module coalescing_range_set_core_tb;
	import crs_pkg::*;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;
	localparam int unsigned CAPACITY = MAX_SEGS_DEF;
	localparam int unsigned FILL_SLOTS = 80;
	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned OPENING_ROWS = 24;
	localparam int unsigned ALL_ROWS = 28;
	localparam logic [FIELD_W-1:0] POS_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [SUM_W-1:0] SPACE_SIZE = 49'h1_0000_0000_0000;
	localparam logic [FIELD_W-1:0] REGION_SPAN = 48'd8192;

	typedef struct packed {
		crs_status_t         status;
		logic                hit;
		logic [HIDX_W-1:0]   hit_index;
		logic [RCNT_W-1:0]   range_count;
		logic [SUM_W-1:0]    covered_total;
	} result_t;

	typedef struct packed {
		logic                kind;
		logic [FIELD_W-1:0]  start;
		logic [FIELD_W-1:0]  length;
		logic [FIELD_W-1:0]  position;
		logic                typed;
		result_t             want;
	} stim_row_t;

	localparam result_t UNTYPED = '{STATUS_OK, 1'b0, 6'd0, 7'd0, 49'd0};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                req_type = REQ_INSERT;
	logic [FIELD_W-1:0]  range_start = '0;
	logic [FIELD_W-1:0]  range_length = '0;
	logic [FIELD_W-1:0]  position = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                hit;
	logic [HIDX_W-1:0]   hit_index;
	logic [RCNT_W-1:0]   range_count;
	logic [SUM_W-1:0]    covered_total;

	// behavioral copy of the range list
	logic [FIELD_W-1:0]  span_start [CAPACITY];
	logic [LEN_W-1:0]    span_len [CAPACITY];
	int unsigned         span_count = 0;
	logic [SUM_W-1:0]    span_total = '0;

	result_t             pending_results [$];
	int unsigned         mismatch_count = 0;
	int unsigned         counted_items = 0;
	bit                  steady = 1'b0;

	stim_row_t table_rows [ALL_ROWS] = '{
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd0, 1'b1, '{STATUS_OK, 1'b0, 6'd0, 7'd0, 49'd0}},
		'{REQ_LOOKUP, 48'd0, 48'd0, POS_MAX, 1'b1, '{STATUS_OK, 1'b0, 6'd0, 7'd0, 49'd0}},
		'{REQ_INSERT, 48'd5, 48'd0, POS_MAX, 1'b1, '{STATUS_EMPTY, 1'b0, 6'd0, 7'd0, 49'd0}},
		'{REQ_INSERT, POS_MAX, POS_MAX, 48'd0, 1'b1, '{STATUS_RANGE, 1'b0, 6'd0, 7'd0, 49'd0}},
		'{REQ_INSERT, 48'd2, POS_MAX, 48'd0, 1'b1, '{STATUS_RANGE, 1'b0, 6'd0, 7'd0, 49'd0}},
		'{REQ_INSERT, POS_MAX, 48'd1, 48'd0, 1'b1, '{STATUS_OK, 1'b0, 6'd0, 7'd1, 49'd1}},
		'{REQ_INSERT, POS_MAX, 48'd2, 48'd0, 1'b1, '{STATUS_RANGE, 1'b0, 6'd0, 7'd1, 49'd1}},
		'{REQ_LOOKUP, POS_MAX, POS_MAX, POS_MAX, 1'b1, '{STATUS_OK, 1'b1, 6'd0, 7'd1, 49'd1}},
		'{REQ_INSERT, 48'd100, 48'd10, POS_MAX, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd120, 48'd5, 48'd0, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd110, 48'd10, 48'd0, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd90, 48'd10, 48'd0, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd125, 48'd1, 48'd0, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd95, 48'd5, 48'd0, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd0, 48'd1, 48'd0, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd50, 48'd3, 48'd0, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd0, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd1, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd52, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd53, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd125, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd126, 1'b0, UNTYPED},
		'{REQ_INSERT, 48'd1, 48'd49, 48'd0, 1'b0, UNTYPED},
		'{REQ_LOOKUP, 48'd0, 48'd0, POS_MAX, 1'b0, UNTYPED},
		// closing rows: one range swallows the whole space
		'{REQ_INSERT, 48'd0, POS_MAX, 48'd0, 1'b1, '{STATUS_OK, 1'b0, 6'd0, 7'd1, SPACE_SIZE}},
		'{REQ_LOOKUP, 48'd0, 48'd0, POS_MAX, 1'b1, '{STATUS_OK, 1'b1, 6'd0, 7'd1, SPACE_SIZE}},
		'{REQ_LOOKUP, 48'd0, 48'd0, 48'd0, 1'b1, '{STATUS_OK, 1'b1, 6'd0, 7'd1, SPACE_SIZE}},
		'{REQ_INSERT, 48'd5, 48'd7, 48'd0, 1'b1, '{STATUS_OK, 1'b0, 6'd0, 7'd1, SPACE_SIZE}}
	};

	coalescing_range_set_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.range_start   (range_start),
		.range_length  (range_length),
		.position      (position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.hit           (hit),
		.hit_index     (hit_index),
		.range_count   (range_count),
		.covered_total (covered_total)
	);

	always #1 clk = ~clk;

	function automatic logic [FIELD_W-1:0] rand_pos();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[FIELD_W-1:0];
	endfunction

	function automatic stim_row_t make_row(input logic kind, input logic [FIELD_W-1:0] s,
			input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] p);
		stim_row_t row;
		row = '{kind, s, l, p, 1'b0, UNTYPED};
		return row;
	endfunction

	// updates the list copy and returns the result the request should produce
	function automatic result_t apply_request(input stim_row_t row);
		result_t res;
		logic [SUM_W-1:0] lo, hi, seg_end;
		int unsigned first, last, drop, k;
		res = UNTYPED;
		if (row.kind == REQ_LOOKUP) begin
			for (k = 0; k < span_count; k++) begin
				if (row.position < span_start[k])
					break;
				if ({1'b0, row.position} < {1'b0, span_start[k]} + span_len[k]) begin
					res.hit = 1'b1;
					res.hit_index = HIDX_W'(k);
					break;
				end
			end
		end else if (row.length == '0) begin
			res.status = STATUS_EMPTY;
		end else begin
			lo = {1'b0, row.start};
			hi = lo + {1'b0, row.length};
			if (hi > SPACE_SIZE) begin
				res.status = STATUS_RANGE;
			end else begin
				first = 0;
				while (first < span_count && {1'b0, span_start[first]} + span_len[first] < lo)
					first++;
				last = first;
				while (last < span_count && {1'b0, span_start[last]} <= hi)
					last++;
				drop = last - first;
				if (drop == 0 && span_count >= CAPACITY) begin
					res.status = STATUS_FULL;
				end else begin
					for (k = first; k < last; k++) begin
						seg_end = {1'b0, span_start[k]} + span_len[k];
						if (seg_end > hi)
							hi = seg_end;
						if ({1'b0, span_start[k]} < lo)
							lo = {1'b0, span_start[k]};
						span_total = span_total - span_len[k];
					end
					if (drop > 0) begin
						for (k = 0; k < span_count - last; k++) begin
							span_start[first + 1 + k] = span_start[last + k];
							span_len[first + 1 + k] = span_len[last + k];
						end
						span_count = span_count - (drop - 1);
					end else begin
						for (k = span_count; k > first; k--) begin
							span_start[k] = span_start[k - 1];
							span_len[k] = span_len[k - 1];
						end
						span_count++;
					end
					span_start[first] = lo[FIELD_W-1:0];
					span_len[first] = hi - lo;
					span_total = span_total + (hi - lo);
				end
			end
		end
		res.range_count = RCNT_W'(span_count);
		res.covered_total = span_total;
		return res;
	endfunction

	task automatic issue_request(input stim_row_t row);
		int unsigned gap;
		result_t want;
		gap = steady ? 0 : $urandom_range(0, 4);
		want = apply_request(row);
		if (row.typed)
			want = row.want;
		counted_items++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_results.push_back(want);
		in_valid <= 1'b1;
		req_type <= row.kind;
		range_start <= row.start;
		range_length <= row.length;
		position <= row.position;
		do @(posedge clk); while (!in_ready);
	endtask

	// one window of address space: busy traffic, optionally after a fill up to capacity,
	// then one wide insert folds the window back into a single range
	task automatic run_region(input bit fill);
		logic [FIELD_W-1:0] base, s, l;
		int unsigned window, pick, ops, i, j, t;
		int unsigned slot_order [FILL_SLOTS];
		base = rand_pos();
		base[13:0] = '0;
		window = fill ? FILL_SLOTS * 64 : 2048;
		ops = fill ? 40 : 110;
		steady = ($urandom_range(0, 5) == 0);
		if (fill) begin
			for (i = 0; i < FILL_SLOTS; i++)
				slot_order[i] = i;
			for (i = FILL_SLOTS - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = slot_order[i];
				slot_order[i] = slot_order[j];
				slot_order[j] = t;
			end
			for (i = 0; i < FILL_SLOTS; i++) begin
				s = base + FIELD_W'(slot_order[i] * 64 + $urandom_range(1, 20));
				issue_request(make_row(REQ_INSERT, s, FIELD_W'($urandom_range(1, 30)),
					rand_pos()));
			end
		end
		repeat (ops) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				s = base + FIELD_W'($urandom_range(0, window - 1));
				l = FIELD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(65, 600)
					: $urandom_range(1, 64));
				issue_request(make_row(REQ_INSERT, s, l, rand_pos()));
			end else if (pick < 50) begin
				issue_request(make_row(REQ_INSERT, rand_pos(), '0, rand_pos()));
			end else if (pick < 90) begin
				s = base + FIELD_W'($urandom_range(0, window + 700));
				issue_request(make_row(REQ_LOOKUP, rand_pos(), rand_pos(), s));
			end else if (pick < 95) begin
				issue_request(make_row(REQ_LOOKUP, rand_pos(), rand_pos(), rand_pos()));
			end else begin
				s = rand_pos() | 48'h8000_0000_0001;
				l = rand_pos() | 48'h8000_0000_0000;
				issue_request(make_row(REQ_INSERT, s, l, rand_pos()));
			end
		end
		issue_request(make_row(REQ_INSERT, base, REGION_SPAN, rand_pos()));
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result beat with nothing expected");
			mismatch_count++;
		end else begin
			want = pending_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatch_count++;
			end
			if (hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, hit);
				mismatch_count++;
			end
			if (hit_index !== want.hit_index) begin
				$error("hit_index: expected %0d, got %0d", want.hit_index, hit_index);
				mismatch_count++;
			end
			if (range_count !== want.range_count) begin
				$error("range_count: expected %0d, got %0d", want.range_count, range_count);
				mismatch_count++;
			end
			if (covered_total !== want.covered_total) begin
				$error("covered_total: expected %0d, got %0d", want.covered_total,
					covered_total);
				mismatch_count++;
			end
		end
	endtask

	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_result();
		end
	end

	initial begin
		int unsigned r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < OPENING_ROWS; r++)
			issue_request(table_rows[r]);
		while (counted_items < RANDOM_ITEMS)
			run_region($urandom_range(0, 2) == 0);
		steady = 1'b0;
		for (r = OPENING_ROWS; r < ALL_ROWS; r++)
			issue_request(table_rows[r]);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
